/* src/mssc_pkg.sv */
// types, step codes and microcode table for the min square sum counter
`timescale 1ns / 1ps

package mssc_pkg;

    // datapath operation selected by a control word
    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_INIT,
        OP_ROW,
        OP_LOOP,
        OP_WRITE,
        OP_EMIT
    } op_t;

    // jump condition tested by a control word
    typedef enum logic [2:0] {
        CD_ALWAYS,
        CD_NO_INPUT,
        CD_ROW_DONE,
        CD_COL_DONE,
        CD_OUT_BUSY
    } cond_t;

    // step addresses of the program
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW,
        ST_LOOP,
        ST_WRITE,
        ST_EMIT
    } step_t;

    // one control word: jump taken when cond holds, else go to seq
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jump;
        step_t seq;
    } uword_t;

    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 8;
    localparam int TARGET_W    = 11;
    localparam int COUNT_W     = 3;

    // microcode rom
    function automatic uword_t ucode_rom(input step_t s);
        uword_t w;
        begin
            case (s)
                ST_IDLE:  w = '{op: OP_ACCEPT, cond: CD_NO_INPUT, jump: ST_IDLE,  seq: ST_INIT};
                ST_INIT:  w = '{op: OP_INIT,   cond: CD_ALWAYS,   jump: ST_ROW,   seq: ST_ROW};
                ST_ROW:   w = '{op: OP_ROW,    cond: CD_ROW_DONE, jump: ST_EMIT,  seq: ST_LOOP};
                ST_LOOP:  w = '{op: OP_LOOP,   cond: CD_COL_DONE, jump: ST_WRITE, seq: ST_LOOP};
                ST_WRITE: w = '{op: OP_WRITE,  cond: CD_ALWAYS,   jump: ST_ROW,   seq: ST_ROW};
                ST_EMIT:  w = '{op: OP_EMIT,   cond: CD_OUT_BUSY, jump: ST_EMIT,  seq: ST_IDLE};
                default:  w = '{op: OP_ACCEPT, cond: CD_ALWAYS,   jump: ST_IDLE,  seq: ST_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

/* src/min_square_sum_count.sv */
// min_square_sum_count: fewest perfect squares summing to a target, microcoded dp
//
// usage
//   input channel s_axis_*: one transaction carries a target value N in tdata[10:0];
//   values above MAX_TARGET are clamped to MAX_TARGET
//   output channel m_axis_*: one transaction per input carries the count (0..4)
//   in tdata[2:0]
//   a six-step program in a rom drives a datapath around a scratch table of
//   MAX_TARGET+1 three-bit entries with one write port and one registered read port
// scheduling
//   one read of the table per candidate square, overlapped with its compare;
//   one target is worked on at a time
// reset
//   the sequencer returns to the idle step and the output register empties;
//   the table is not cleared, every run rebuilds the entries it reads
// stall
//   the finished count waits in the output register; the next target is taken
//   meanwhile, and its own result waits in the emit step until the register frees
`timescale 1ns / 1ps

module min_square_sum_count #(
    parameter int MAX_TARGET = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mssc_pkg::TDATA_IN_W-1:0]    s_axis_tdata,   // [10:0] target_value
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mssc_pkg::TDATA_OUT_W-1:0]   m_axis_tdata    // [2:0] square_count
);

    import mssc_pkg::*;

    // table index width, counter width (holds MAX_TARGET+1), square width
    localparam int IDX_W = (MAX_TARGET > 1) ? $clog2(MAX_TARGET + 1) : 1;
    localparam int I_W   = $clog2(MAX_TARGET + 2);
    localparam int SQ_W  = I_W + 1;
    localparam int CMP_W = ((I_W > TARGET_W) ? I_W : TARGET_W) + 1;
    localparam int DEPTH = MAX_TARGET + 1;

    // sequencer state
    step_t                upc_reg, upc_next;
    uword_t               uw;
    logic                 cond_true;

    // datapath registers
    logic [I_W-1:0]       n_reg, n_next;          // clamped target
    logic [I_W-1:0]       i_reg, i_next;          // entry being built
    logic [SQ_W-1:0]      sq_reg, sq_next;        // j*j
    logic [SQ_W-1:0]      odd_reg, odd_next;      // 2j+1, step to the next square
    logic [COUNT_W-1:0]   best_reg, best_next;    // running minimum for entry i
    logic [COUNT_W-1:0]   result_reg, result_next;
    logic                 pend_reg, pend_next;    // a read is in flight
    logic [COUNT_W-1:0]   rd_reg;                 // registered table read data

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]   out_data_reg, out_data_next;

    // table
    logic [COUNT_W-1:0]   table_mem [DEPTH];

    // decoded controls and status
    logic                 in_fire;
    logic                 row_done;
    logic                 col_done;
    logic                 out_busy;
    logic                 emit_fire;
    logic                 rd_en;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [COUNT_W-1:0]   wr_data;
    logic [SQ_W-1:0]      rd_diff;
    logic [IDX_W-1:0]     rd_addr;
    logic [COUNT_W:0]     cand;
    logic [CMP_W-1:0]     tgt_ext;
    logic [I_W-1:0]       tgt_sat;

    // status seen by the sequencer
    assign row_done = (i_reg > n_reg);
    assign col_done = (sq_reg > {1'b0, i_reg});
    assign out_busy = out_valid_reg && !m_axis_tready;

    // target clamp
    assign tgt_ext = CMP_W'(s_axis_tdata[TARGET_W-1:0]);
    assign tgt_sat = (tgt_ext > CMP_W'(MAX_TARGET)) ? I_W'(MAX_TARGET) : I_W'(tgt_ext);

    // table addresses, i - j*j is only used while j*j <= i
    assign rd_diff = {1'b0, i_reg} - sq_reg;
    assign rd_addr = rd_diff[IDX_W-1:0];
    assign cand    = {1'b0, rd_reg} + (COUNT_W+1)'(1);

    // control word fetch and decode
    always_comb
    begin
        uw            = ucode_rom(upc_reg);
        s_axis_tready = (uw.op == OP_ACCEPT);
        in_fire       = s_axis_tready && s_axis_tvalid;
        rd_en         = (uw.op == OP_LOOP) && !col_done;
        wr_en         = (uw.op == OP_INIT) || (uw.op == OP_WRITE);
        wr_addr       = (uw.op == OP_INIT) ? '0 : i_reg[IDX_W-1:0];
        wr_data       = (uw.op == OP_INIT) ? '0 : best_reg;
        emit_fire     = (uw.op == OP_EMIT) && !out_busy;
    end

    // jump condition
    always_comb
    begin
        case (uw.cond)
            CD_ALWAYS:   cond_true = 1'b1;
            CD_NO_INPUT: cond_true = !s_axis_tvalid;
            CD_ROW_DONE: cond_true = row_done;
            CD_COL_DONE: cond_true = col_done;
            CD_OUT_BUSY: cond_true = out_busy;
            default:     cond_true = 1'b1;
        endcase
    end

    // next step
    always_comb
    begin
        upc_next = cond_true ? uw.jump : uw.seq;
    end

    // datapath next values
    always_comb
    begin
        n_next      = n_reg;
        i_next      = i_reg;
        sq_next     = sq_reg;
        odd_next    = odd_reg;
        best_next   = best_reg;
        result_next = result_reg;
        pend_next   = pend_reg;
        case (uw.op)
            OP_ACCEPT:
            begin
                if (in_fire)
                begin
                    n_next      = tgt_sat;
                    result_next = '0;
                end
            end
            OP_INIT:
            begin
                i_next = I_W'(1);
            end
            OP_ROW:
            begin
                sq_next   = SQ_W'(1);
                odd_next  = SQ_W'(3);
                best_next = '1;
                pend_next = 1'b0;
            end
            OP_LOOP:
            begin
                // compare the entry read last cycle while the next read goes out
                if (pend_reg && (cand < {1'b0, best_reg}))
                begin
                    best_next = cand[COUNT_W-1:0];
                end
                if (!col_done)
                begin
                    sq_next   = sq_reg + odd_reg;
                    odd_next  = odd_reg + SQ_W'(2);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            OP_WRITE:
            begin
                if (i_reg == n_reg)
                begin
                    result_next = best_reg;
                end
                i_next = i_reg + I_W'(1);
            end
            OP_EMIT:
            begin
                result_next = result_reg;
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    // output register next values
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        i_reg        <= i_next;
        sq_reg       <= sq_next;
        odd_reg      <= odd_next;
        best_reg     <= best_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

    // scratch table, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= table_mem[rd_addr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_OUT_W'(out_data_reg);

    // every entry written in the write step has seen at least one candidate and obeys the four-square bound
    a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == ST_WRITE) |-> (best_reg <= COUNT_W'(4)))
        else $error("table entry out of range");

    // the row counter never runs more than one past the target
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg != ST_IDLE) && (upc_reg != ST_INIT) |-> (i_reg <= n_reg + I_W'(1)))
        else $error("row counter past target");

    // a new result only appears from the emit step
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(upc_reg) == ST_EMIT))
        else $error("result shown outside emit step");

    // reads only go out for squares not above the current entry
    a_rd_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (sq_reg <= {1'b0, i_reg}) && (sq_reg != '0))
        else $error("table read out of row");

endmodule
